@@ rtl/rwm_pkg.sv @@
package rwm_pkg;

  localparam int REQUEST_DEPTH = 16;
  localparam int WORKER_DEPTH  = 16;

  localparam int REQ_PTR_W = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
  localparam int WRK_PTR_W = (WORKER_DEPTH > 1) ? $clog2(WORKER_DEPTH) : 1;
  localparam int REQ_CNT_W = $clog2(REQUEST_DEPTH + 1);
  localparam int WRK_CNT_W = $clog2(WORKER_DEPTH + 1);

  localparam int TAG_W   = 16;
  localparam int WID_W   = 8;
  localparam int CNT_OUT_W = 5;

  typedef enum logic {
    OP_REQUEST     = 1'b0,
    OP_WORKER_FREE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DISPATCHED = 2'd0,
    ST_QUEUED     = 2'd1,
    ST_DROPPED    = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [TAG_W-1:0]  request_tag;
    logic [WID_W-1:0]  worker_id;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [TAG_W-1:0]     out_request;
    logic [WID_W-1:0]     out_worker;
    logic [CNT_OUT_W-1:0] pending_requests;
    logic [CNT_OUT_W-1:0] idle_workers;
  } out_t;

endpackage

@@ rtl/rwm_in_reg.sv @@
module rwm_in_reg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  rwm_pkg::in_t in_item,
  output logic         valid,
  output rwm_pkg::in_t item
);

  logic         valid_r;
  rwm_pkg::in_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

@@ rtl/rwm_core.sv @@
module rwm_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid,
  input  rwm_pkg::in_t  item,
  output logic          out_strobe,
  output rwm_pkg::out_t out_item
);

  localparam int RQ_D = rwm_pkg::REQUEST_DEPTH;
  localparam int WK_D = rwm_pkg::WORKER_DEPTH;
  localparam int RP_W = rwm_pkg::REQ_PTR_W;
  localparam int WP_W = rwm_pkg::WRK_PTR_W;
  localparam int RC_W = rwm_pkg::REQ_CNT_W;
  localparam int WC_W = rwm_pkg::WRK_CNT_W;

  logic [rwm_pkg::TAG_W-1:0] req_mem [RQ_D];
  logic [rwm_pkg::WID_W-1:0] wrk_mem [WK_D];

  logic [RP_W-1:0] req_head_r, req_head_nxt;
  logic [RC_W-1:0] req_cnt_r, req_cnt_nxt;
  logic [WP_W-1:0] wrk_head_r, wrk_head_nxt;
  logic [WC_W-1:0] wrk_cnt_r, wrk_cnt_nxt;

  logic            strobe_r;
  rwm_pkg::out_t   res_r, res_nxt;

  logic req_push, req_pop, wrk_push, wrk_pop;
  logic req_empty, req_full, wrk_empty, wrk_full;
  logic [RC_W:0]   req_wsum;
  logic [WC_W:0]   wrk_wsum;
  logic [RP_W-1:0] req_widx;
  logic [WP_W-1:0] wrk_widx;
  logic [RP_W-1:0] req_head_inc;
  logic [WP_W-1:0] wrk_head_inc;

  assign req_empty = (req_cnt_r == '0);
  assign wrk_empty = (wrk_cnt_r == '0);
  assign req_full  = (req_cnt_r == RC_W'(RQ_D));
  assign wrk_full  = (wrk_cnt_r == WC_W'(WK_D));

  assign req_pop  = valid && item.opcode == rwm_pkg::OP_WORKER_FREE && !req_empty;
  assign wrk_pop  = valid && item.opcode == rwm_pkg::OP_REQUEST && !wrk_empty;
  assign req_push = valid && item.opcode == rwm_pkg::OP_REQUEST && wrk_empty && !req_full;
  assign wrk_push = valid && item.opcode == rwm_pkg::OP_WORKER_FREE && req_empty && !wrk_full;

  // tail slot = head + count, wrapped once (sum stays below twice the depth)
  always_comb begin
    req_wsum = (RC_W+1)'(req_head_r) + (RC_W+1)'(req_cnt_r);
    if (req_wsum >= (RC_W+1)'(RQ_D)) begin
      req_wsum = req_wsum - (RC_W+1)'(RQ_D);
    end
    req_widx = req_wsum[RP_W-1:0];
    wrk_wsum = (WC_W+1)'(wrk_head_r) + (WC_W+1)'(wrk_cnt_r);
    if (wrk_wsum >= (WC_W+1)'(WK_D)) begin
      wrk_wsum = wrk_wsum - (WC_W+1)'(WK_D);
    end
    wrk_widx = wrk_wsum[WP_W-1:0];
  end

  assign req_head_inc = (req_head_r == RP_W'(RQ_D - 1)) ? '0 : req_head_r + 1'b1;
  assign wrk_head_inc = (wrk_head_r == WP_W'(WK_D - 1)) ? '0 : wrk_head_r + 1'b1;

  always_comb begin
    req_head_nxt = req_head_r;
    req_cnt_nxt  = req_cnt_r;
    wrk_head_nxt = wrk_head_r;
    wrk_cnt_nxt  = wrk_cnt_r;
    if (req_pop) begin
      req_head_nxt = req_head_inc;
      req_cnt_nxt  = req_cnt_r - 1'b1;
    end
    if (req_push) begin
      req_cnt_nxt = req_cnt_r + 1'b1;
    end
    if (wrk_pop) begin
      wrk_head_nxt = wrk_head_inc;
      wrk_cnt_nxt  = wrk_cnt_r - 1'b1;
    end
    if (wrk_push) begin
      wrk_cnt_nxt = wrk_cnt_r + 1'b1;
    end
  end

  always_comb begin
    res_nxt             = '0;
    res_nxt.status      = rwm_pkg::ST_DROPPED;
    if (req_pop || wrk_pop) begin
      res_nxt.status = rwm_pkg::ST_DISPATCHED;
    end else if (req_push || wrk_push) begin
      res_nxt.status = rwm_pkg::ST_QUEUED;
    end
    if (wrk_pop) begin
      res_nxt.out_request = item.request_tag;
      res_nxt.out_worker  = wrk_mem[wrk_head_r];
    end else if (req_pop) begin
      res_nxt.out_request = req_mem[req_head_r];
      res_nxt.out_worker  = item.worker_id;
    end
    res_nxt.pending_requests = rwm_pkg::CNT_OUT_W'(req_cnt_nxt);
    res_nxt.idle_workers     = rwm_pkg::CNT_OUT_W'(wrk_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_head_r <= '0;
      req_cnt_r  <= '0;
      wrk_head_r <= '0;
      wrk_cnt_r  <= '0;
      strobe_r   <= 1'b0;
    end else begin
      req_head_r <= req_head_nxt;
      req_cnt_r  <= req_cnt_nxt;
      wrk_head_r <= wrk_head_nxt;
      wrk_cnt_r  <= wrk_cnt_nxt;
      strobe_r   <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_push) begin
      req_mem[req_widx] <= item.request_tag;
    end
    if (wrk_push) begin
      wrk_mem[wrk_widx] <= item.worker_id;
    end
    if (valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = res_r;

`ifndef SYNTH
  // a request and a free worker never wait at the same time
  a_not_both_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    req_empty || wrk_empty)
    else $error("requests and workers both queued");

  a_req_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    req_cnt_r <= RC_W'(RQ_D))
    else $error("request count above depth");

  a_wrk_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wrk_cnt_r <= WC_W'(WK_D))
    else $error("worker count above depth");

  // a drop leaves both counts as they were
  a_drop_holds_counts: assert property (@(posedge clk) disable iff (!rst_n)
    valid && !req_pop && !wrk_pop && !req_push && !wrk_push |=>
      $stable(req_cnt_r) && $stable(wrk_cnt_r))
    else $error("count changed on dropped item");

  a_strobe_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    valid |=> out_strobe)
    else $error("missing result strobe");
`endif

endmodule

@@ rtl/request_worker_matcher_unit.sv @@
// request/worker matcher
// Input channel: drive in_item and raise start for one cycle per event. An
// event is transferred at a rising edge with start high and busy low; busy
// is always low, so one event may be transferred in every cycle.
// opcode request: pairs the tag with the oldest free worker, or queues it.
// opcode worker free: pairs the worker with the oldest pending request, or
// queues it. A push onto a full queue drops the item (status dropped).
// Result channel: out_strobe is high for exactly one cycle with out_item;
// that result is transferred at the edge closing that cycle. One result per
// event, in event order.
// An event passes through the input register, then the matching logic into
// the result register, and its result is then strobed on out_strobe.
// Throughput: 1 event per cycle, as both queues are updated once per event.
// Reset (rst_n low at a clock edge) empties both queues and drops any event
// still in flight; queue contents are not cleared.
// The receiver cannot stall: results must be taken when strobed.
module request_worker_matcher_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rwm_pkg::in_t  in_item,
  output logic          out_strobe,
  output rwm_pkg::out_t out_item
);

  logic         item_valid;
  rwm_pkg::in_t item;

  assign busy = 1'b0;

  rwm_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .valid   (item_valid),
    .item    (item)
  );

  rwm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (item_valid),
    .item       (item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

@@ test/request_worker_matcher_check.sv @@
module request_worker_matcher_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  rwm_pkg::in_t  in_item,
  input  logic          out_strobe,
  input  rwm_pkg::out_t out_item,
  output int            fail_count,
  output int            results_seen,
  output int            drops_seen,
  output int            awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state: tags waiting for a worker, workers waiting for a tag
  logic [rwm_pkg::TAG_W-1:0] waiting_tags[$];
  logic [rwm_pkg::WID_W-1:0] idle_ids[$];
  rwm_pkg::out_t             expected_results[$];

  int errors;
  int checked;
  int drops;
  int reported;

  function automatic rwm_pkg::out_t dispatch_step(input rwm_pkg::in_t ev);
    rwm_pkg::out_t r;
    r = '0;
    if (ev.opcode == rwm_pkg::OP_REQUEST) begin
      if (idle_ids.size() != 0) begin
        r.status      = rwm_pkg::ST_DISPATCHED;
        r.out_request = ev.request_tag;
        r.out_worker  = idle_ids[0];
        idle_ids.delete(0);
      end else if (waiting_tags.size() < rwm_pkg::REQUEST_DEPTH) begin
        waiting_tags = {waiting_tags, ev.request_tag};
        r.status = rwm_pkg::ST_QUEUED;
      end else begin
        r.status = rwm_pkg::ST_DROPPED;
      end
    end else begin
      if (waiting_tags.size() != 0) begin
        r.status      = rwm_pkg::ST_DISPATCHED;
        r.out_request = waiting_tags[0];
        waiting_tags.delete(0);
        r.out_worker  = ev.worker_id;
      end else if (idle_ids.size() < rwm_pkg::WORKER_DEPTH) begin
        idle_ids = {idle_ids, ev.worker_id};
        r.status = rwm_pkg::ST_QUEUED;
      end else begin
        r.status = rwm_pkg::ST_DROPPED;
      end
    end
    r.pending_requests = rwm_pkg::CNT_OUT_W'(waiting_tags.size());
    r.idle_workers     = rwm_pkg::CNT_OUT_W'(idle_ids.size());
    return r;
  endfunction

  task automatic check_result(input rwm_pkg::out_t got);
    rwm_pkg::out_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (reported < 10) begin
        $display("%0t: result with nothing awaited: status %0d req %h wrk %h pend %0d idle %0d",
                 $realtime, got.status, got.out_request, got.out_worker,
                 got.pending_requests, got.idle_workers);
      end
      reported++;
    end else begin
      want = expected_results[0];
      expected_results.delete(0);
      checked++;
      if (got.status !== want.status || got.out_request !== want.out_request ||
          got.out_worker !== want.out_worker ||
          got.pending_requests !== want.pending_requests ||
          got.idle_workers !== want.idle_workers) begin
        errors++;
        if (reported < 10) begin
          $display("%0t: mismatch on result %0d", $realtime, checked);
          $display("  expected: status %0d req %h wrk %h pend %0d idle %0d",
                   want.status, want.out_request, want.out_worker,
                   want.pending_requests, want.idle_workers);
          $display("  actual:   status %0d req %h wrk %h pend %0d idle %0d",
                   got.status, got.out_request, got.out_worker,
                   got.pending_requests, got.idle_workers);
        end
        reported++;
      end
    end
  endtask

  always @(posedge clk) begin
    rwm_pkg::out_t pred;
    if (rst_n) begin
      // results are for earlier transfers, so compare before predicting this one
      if (out_strobe !== 1'b0) check_result(out_item);
      if (start && !busy) begin
        pred = dispatch_step(in_item);
        expected_results = {expected_results, pred};
        if (pred.status == rwm_pkg::ST_DROPPED) drops++;
      end
    end
    fail_count   <= errors;
    results_seen <= checked;
    drops_seen   <= drops;
    awaited      <= expected_results.size();
  end

endmodule

@@ test/request_worker_matcher_unit_test.sv @@
module request_worker_matcher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_EVENTS = 577;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  rwm_pkg::in_t  in_item;
  logic          out_strobe;
  rwm_pkg::out_t out_item;

  int fail_count;
  int results_seen;
  int drops_seen;
  int awaited;
  int events_sent;
  int idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_worker_matcher_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  request_worker_matcher_check i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .results_seen(results_seen),
    .drops_seen  (drops_seen),
    .awaited     (awaited)
  );

  function automatic rwm_pkg::in_t make_event(input rwm_pkg::opcode_t op,
                                              input logic [rwm_pkg::TAG_W-1:0] tag,
                                              input logic [rwm_pkg::WID_W-1:0] wid);
    rwm_pkg::in_t ev;
    ev.opcode      = op;
    ev.request_tag = tag;
    ev.worker_id   = wid;
    return ev;
  endfunction

  // one transfer: optional idle cycles, then hold start until busy is low
  task automatic send_event(input rwm_pkg::in_t ev);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_item = ev;
    @(posedge clk);
    while (busy) @(posedge clk);
    events_sent++;
  endtask

  initial begin
    #2_000_000;
    $display("timeout: %0d expected results still outstanding", awaited);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int               phase_count;
    int               burst_len;
    int               free_pct;
    int               wait_cycles;
    rwm_pkg::opcode_t op;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    events_sent = 0;
    idle_pct    = 6;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // fill the worker queue with extreme ids first, overflow it, then drain two
    send_event(make_event(rwm_pkg::OP_WORKER_FREE, rwm_pkg::TAG_W'($urandom), 8'h00));
    send_event(make_event(rwm_pkg::OP_WORKER_FREE, rwm_pkg::TAG_W'($urandom), 8'hFF));
    repeat (rwm_pkg::WORKER_DEPTH - 2) begin
      send_event(make_event(rwm_pkg::OP_WORKER_FREE, rwm_pkg::TAG_W'($urandom),
                            rwm_pkg::WID_W'($urandom)));
    end
    send_event(make_event(rwm_pkg::OP_WORKER_FREE, rwm_pkg::TAG_W'($urandom), 8'hA5));
    send_event(make_event(rwm_pkg::OP_REQUEST, 16'h0000, rwm_pkg::WID_W'($urandom)));
    send_event(make_event(rwm_pkg::OP_REQUEST, 16'hFFFF, rwm_pkg::WID_W'($urandom)));

    // bursts leaning one way push a queue to full, the other way to empty
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct    = (phase == 0) ? 6 : (phase == 1) ? 63 : 0;
      phase_count = 0;
      while (phase_count < PHASE_EVENTS) begin
        case ($urandom_range(2))
          0: free_pct = 10;
          1: free_pct = 50;
          default: free_pct = 90;
        endcase
        burst_len = $urandom_range(4, 40);
        for (int i = 0; i < burst_len && phase_count < PHASE_EVENTS; i++) begin
          op = ($urandom_range(99) < free_pct) ? rwm_pkg::OP_WORKER_FREE : rwm_pkg::OP_REQUEST;
          send_event(make_event(op, rwm_pkg::TAG_W'($urandom), rwm_pkg::WID_W'($urandom)));
          phase_count++;
        end
      end
    end

    @(negedge clk);
    start = 1'b0;

    for (wait_cycles = 0; wait_cycles < 200 && awaited != 0; wait_cycles++) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);

    if (awaited != 0) $display("%0d expected results never arrived", awaited);
    $display("sent %0d events (fill, overflow and drain of both queues) over three pacing phases",
             events_sent);
    $display("compared %0d results, %0d of them drops on a full queue", results_seen,
             drops_seen);
    if (fail_count == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
